// ===== rtl/efft_pkg.sv =====
// ----------------------------------------------------------------------------
// efft_pkg: shared types and constants of the ellipse fan tessellator
// Field widths, fixed-point constants, the arctangent table of the rotation
// cells and the transaction records that travel down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package efft_pkg;

    // field widths
    localparam int IDX_W      = 13;
    localparam int SEG_W      = 13;
    localparam int RAD_W      = 16;
    localparam int COORD_W    = 17;
    localparam int PHASE_W    = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // internal fixed point: unit vector in q2.30, angle in 2^-32 of a turn
    localparam int UNIT_W     = 33;
    localparam int FRAC_BITS  = 30;
    localparam int SCALE_W    = RAD_W + 1 + UNIT_W;
    localparam int ROUND_W    = SCALE_W - FRAC_BITS;

    // limits and defaults
    localparam int MAX_SEGMENTS      = 4096;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam logic [RAD_W-1:0] RADIUS_RESET  = RAD_W'(256);
    localparam logic [SEG_W-1:0] SEGMENT_RESET = SEG_W'(32);

    localparam logic signed [UNIT_W-1:0]  GAIN_Q30    = UNIT_W'(64'sd652032874);
    localparam logic signed [UNIT_W-1:0]  HALF_PI_Q30 = UNIT_W'(64'sd1686629713);
    localparam logic signed [UNIT_W-1:0]  Q30_HALF    = UNIT_W'(64'sd536870912);
    localparam logic signed [ROUND_W-1:0] OUT_LIMIT   = ROUND_W'(64'sd65535);

    // quadrant offset added before reduction (one eighth of a turn)
    localparam logic [PHASE_W-1:0] EIGHTH_TURN = PHASE_W'(16'h2000);

    // atan(2^-i) in units of 2^-32 of a full turn
    localparam int ATAN_TAB [ATAN_ENTRIES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // register map (word index on the apb port)
    typedef enum logic [1:0] {
        REG_RADIUS_X,
        REG_RADIUS_Y,
        REG_SEGMENT_COUNT
    } t_reg_idx;

    // quadrant after reduction to the nearest axis
    typedef enum logic [1:0] {
        QUAD_EAST,
        QUAD_NORTH,
        QUAD_WEST,
        QUAD_SOUTH
    } t_quad;

    // per-transaction side information carried to the output
    typedef struct packed {
        logic             tri_valid;
        logic [IDX_W-1:0] tri_second;
        logic [IDX_W-1:0] tri_third;
        logic             index_error;
        logic             zero_xy;
    } t_meta;

    // record between divider cells
    typedef struct packed {
        logic               live;
        t_meta              meta;
        logic [SEG_W-1:0]   rem;
        logic [PHASE_W-1:0] quo;
    } t_div_item;

    // record between rotation cells
    typedef struct packed {
        logic                     live;
        t_meta                    meta;
        t_quad                    quad;
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] z;
    } t_cordic_item;

endpackage

`default_nettype wire

// ===== rtl/efft_div_cell.sv =====
// ----------------------------------------------------------------------------
// efft_div_cell: one restoring division step of the phase divider
// Doubles the partial remainder, subtracts the segment count when it fits
// and shifts one quotient bit into the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module efft_div_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [efft_pkg::SEG_W-1:0] i_n,
    input  wire efft_pkg::t_div_item      i_item,
    output efft_pkg::t_div_item           o_item
);
    import efft_pkg::*;

    logic [SEG_W:0]   w_rem2;
    logic             w_fits;
    logic [SEG_W:0]   w_diff;
    t_div_item        n_item;
    logic             r_live;
    t_div_item        r_item;

    // one quotient bit
    always_comb begin
        w_rem2 = {i_item.rem, 1'b0};
        w_fits = (w_rem2 >= {1'b0, i_n});
        w_diff = w_rem2 - {1'b0, i_n};
        n_item = i_item;
        n_item.rem = w_fits ? w_diff[SEG_W-1:0] : w_rem2[SEG_W-1:0];
        n_item.quo = {i_item.quo[PHASE_W-2:0], w_fits};
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= i_item.live;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    always_comb begin
        o_item = r_item;
        o_item.live = r_live;
    end

endmodule

`default_nettype wire

// ===== rtl/efft_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// efft_cordic_cell: one rotation step of the sine/cosine chain
// Rotates the vector by plus or minus atan(2^-STAGE) toward zero residual
// angle and registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module efft_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire efft_pkg::t_cordic_item i_item,
    output efft_pkg::t_cordic_item      o_item
);
    import efft_pkg::*;

    localparam logic signed [UNIT_W-1:0] ATAN = UNIT_W'(ATAN_TAB[STAGE]);

    logic signed [UNIT_W-1:0] w_dx;
    logic signed [UNIT_W-1:0] w_dy;
    t_cordic_item             n_item;
    logic                     r_live;
    t_cordic_item             r_item;

    // micro-rotation, direction from the sign of the residual angle
    always_comb begin
        w_dx   = i_item.y >>> STAGE;
        w_dy   = i_item.x >>> STAGE;
        n_item = i_item;
        if (!i_item.z[UNIT_W-1]) begin
            n_item.x = i_item.x - w_dx;
            n_item.y = i_item.y + w_dy;
            n_item.z = i_item.z - ATAN;
        end else begin
            n_item.x = i_item.x + w_dx;
            n_item.y = i_item.y - w_dy;
            n_item.z = i_item.z + ATAN;
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= i_item.live;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    always_comb begin
        o_item = r_item;
        o_item.live = r_live;
    end

endmodule

`default_nettype wire

// ===== rtl/efft_post.sv =====
// ----------------------------------------------------------------------------
// efft_post: residual correction, quadrant mapping and radius scaling
// Four register stages: residual angle, correction products, unit vector
// in its quadrant, and the rounded, saturated q8.8 vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module efft_post (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire efft_pkg::t_cordic_item        i_item,
    input  wire logic [efft_pkg::RAD_W-1:0]    i_radius_x,
    input  wire logic [efft_pkg::RAD_W-1:0]    i_radius_y,
    output logic                               o_result_valid,
    output logic signed [efft_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [efft_pkg::COORD_W-1:0] o_pos_y,
    output logic                               o_tri_valid,
    output logic [efft_pkg::IDX_W-1:0]         o_tri_second,
    output logic [efft_pkg::IDX_W-1:0]         o_tri_third,
    output logic                               o_index_error
);
    import efft_pkg::*;

    localparam int PROD_W = 2 * UNIT_W;

    // stage 1: residual angle in radians
    logic signed [PROD_W-1:0] w_zprod;
    logic signed [UNIT_W-1:0] r1_zr, r1_x, r1_y;
    t_quad                    r1_quad;
    t_meta                    r1_meta;
    logic                     r1_live;

    // stage 2: correction terms
    logic signed [PROD_W-1:0] w_xprod, w_yprod;
    logic signed [UNIT_W-1:0] r2_tx, r2_ty, r2_x, r2_y;
    t_quad                    r2_quad;
    t_meta                    r2_meta;
    logic                     r2_live;

    // stage 3: unit vector
    logic signed [UNIT_W-1:0] w_nx, w_ny, n_c, n_s;
    logic signed [UNIT_W-1:0] r3_c, r3_s;
    t_meta                    r3_meta;
    logic                     r3_live;

    // stage 4: scaled vertex
    logic signed [SCALE_W-1:0] w_sx, w_sy;
    logic signed [ROUND_W-1:0] w_vx, w_vy;
    logic signed [COORD_W-1:0] n_pos_x, n_pos_y;

    // residual angle times pi/2
    assign w_zprod = i_item.z * HALF_PI_Q30;

    always_ff @(posedge i_clk) begin
        r1_zr   <= w_zprod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r1_x    <= i_item.x;
        r1_y    <= i_item.y;
        r1_quad <= i_item.quad;
        r1_meta <= i_item.meta;
    end

    // first-order rotation by the residual
    assign w_xprod = r1_x * r1_zr;
    assign w_yprod = r1_y * r1_zr;

    always_ff @(posedge i_clk) begin
        r2_tx   <= w_xprod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r2_ty   <= w_yprod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r2_x    <= r1_x;
        r2_y    <= r1_y;
        r2_quad <= r1_quad;
        r2_meta <= r1_meta;
    end

    // corrected vector mapped back to its quadrant
    always_comb begin
        w_nx = r2_x - r2_ty;
        w_ny = r2_y + r2_tx;
        case (r2_quad)
            QUAD_EAST: begin
                n_c = w_nx;
                n_s = w_ny;
            end
            QUAD_NORTH: begin
                n_c = -w_ny;
                n_s = w_nx;
            end
            QUAD_WEST: begin
                n_c = -w_nx;
                n_s = -w_ny;
            end
            default: begin
                n_c = w_ny;
                n_s = -w_nx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_c    <= n_c;
        r3_s    <= n_s;
        r3_meta <= r2_meta;
    end

    // radius scaling, round half up, saturate
    always_comb begin
        w_sx = $signed({1'b0, i_radius_x}) * r3_c + SCALE_W'(Q30_HALF);
        w_sy = $signed({1'b0, i_radius_y}) * r3_s + SCALE_W'(Q30_HALF);
        w_vx = w_sx[SCALE_W-1:FRAC_BITS];
        w_vy = w_sy[SCALE_W-1:FRAC_BITS];
        if (w_vx > OUT_LIMIT) begin
            n_pos_x = COORD_W'(OUT_LIMIT);
        end else if (w_vx < -OUT_LIMIT) begin
            n_pos_x = COORD_W'(-OUT_LIMIT);
        end else begin
            n_pos_x = w_vx[COORD_W-1:0];
        end
        if (w_vy > OUT_LIMIT) begin
            n_pos_y = COORD_W'(OUT_LIMIT);
        end else if (w_vy < -OUT_LIMIT) begin
            n_pos_y = COORD_W'(-OUT_LIMIT);
        end else begin
            n_pos_y = w_vy[COORD_W-1:0];
        end
        if (r3_meta.zero_xy) begin
            n_pos_x = '0;
            n_pos_y = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        o_pos_x       <= n_pos_x;
        o_pos_y       <= n_pos_y;
        o_tri_valid   <= r3_meta.tri_valid;
        o_tri_second  <= r3_meta.tri_second;
        o_tri_third   <= r3_meta.tri_third;
        o_index_error <= r3_meta.index_error;
    end

    // occupancy through the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_live        <= 1'b0;
            r2_live        <= 1'b0;
            r3_live        <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r1_live        <= i_item.live;
            r2_live        <= r1_live;
            r3_live        <= r2_live;
            o_result_valid <= r3_live;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ellipse_fan_tessellator.sv =====
// ----------------------------------------------------------------------------
// ellipse_fan_tessellator: vertex and fan triangle of a tessellated ellipse
// Per position: the q8.8 vertex on the ellipse and the fan triangle that
// starts there, through a chain of divider and rotation cells.
// ----------------------------------------------------------------------------
// Usage:
// - a transaction is taken at each clock edge with start high and busy low;
//   busy stays low, so a new position may enter every cycle
// - each result is shown for one cycle with o_result_valid high, in the
//   order the positions came in, once it has passed the entry register,
//   the divider cells, the rotation cells and the four output stages
// - throughput is one vertex per cycle: an entry register, 16 divider cells
//   (one phase bit each), CORDIC_STAGES rotation cells and four output
//   stages all advance together every cycle
// - radius_x, radius_y and segment_count sit on the apb port at byte
//   addresses 0, 4 and 8; write them only while no transaction is in flight
// - reset restores radius 1.0 on both axes and 32 segments, and drops any
//   transaction in flight
// - the receiver cannot hold results back; results are never stalled
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_fan_tessellator #(
    parameter int CORDIC_STAGES = efft_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // apb configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [efft_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [efft_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [efft_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [efft_pkg::IDX_W-1:0]        i_position,
    // result channel
    output logic                                   o_result_valid,
    output logic signed [efft_pkg::COORD_W-1:0]    o_pos_x,
    output logic signed [efft_pkg::COORD_W-1:0]    o_pos_y,
    output logic                                   o_tri_valid,
    output logic [efft_pkg::IDX_W-1:0]             o_tri_second,
    output logic [efft_pkg::IDX_W-1:0]             o_tri_third,
    output logic                                   o_index_error
);
    import efft_pkg::*;

    localparam int DIV_STEPS = PHASE_W;

    // configuration registers
    logic [RAD_W-1:0] r_radius_x;
    logic [RAD_W-1:0] r_radius_y;
    logic [SEG_W-1:0] r_segment_count;
    logic [SEG_W-1:0] r_n_eff;
    logic [SEG_W-1:0] n_n_eff;
    logic             w_cfg_wr;
    t_reg_idx         w_reg_idx;

    // entry stage
    logic [IDX_W:0]   w_k_ext;
    logic [IDX_W-1:0] w_k_minus1;
    t_div_item        n_entry;
    t_div_item        r_entry;
    logic             r_entry_live;

    // cell chains
    t_div_item        div_bus [DIV_STEPS+1];
    t_cordic_item     cordic_bus [CORDIC_STAGES+1];
    logic [PHASE_W-1:0] w_biased;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    // segment count held inside 1..MAX_SEGMENTS
    always_comb begin
        n_n_eff = pwdata[SEG_W-1:0];
        if (pwdata[SEG_W-1:0] == '0) begin
            n_n_eff = SEG_W'(1);
        end else if (pwdata[SEG_W-1:0] > SEG_W'(MAX_SEGMENTS)) begin
            n_n_eff = SEG_W'(MAX_SEGMENTS);
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_x      <= RADIUS_RESET;
            r_radius_y      <= RADIUS_RESET;
            r_segment_count <= SEGMENT_RESET;
            r_n_eff         <= SEGMENT_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RADIUS_X: begin
                    r_radius_x <= pwdata[RAD_W-1:0];
                end
                REG_RADIUS_Y: begin
                    r_radius_y <= pwdata[RAD_W-1:0];
                end
                REG_SEGMENT_COUNT: begin
                    r_segment_count <= pwdata[SEG_W-1:0];
                    r_n_eff         <= n_n_eff;
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            REG_RADIUS_X:      prdata = APB_DATA_W'(r_radius_x);
            REG_RADIUS_Y:      prdata = APB_DATA_W'(r_radius_y);
            REG_SEGMENT_COUNT: prdata = APB_DATA_W'(r_segment_count);
            default:           prdata = '0;
        endcase
    end

    // classify the position and seed the divider
    always_comb begin
        w_k_ext    = {1'b0, i_position};
        w_k_minus1 = i_position - IDX_W'(1);
        n_entry    = '0;
        n_entry.live = start && !busy;
        n_entry.meta.index_error = (w_k_ext > ({1'b0, r_n_eff} + (IDX_W+1)'(1)));
        n_entry.meta.zero_xy = (i_position == '0) || n_entry.meta.index_error;
        n_entry.meta.tri_valid = (i_position != '0) && (i_position <= r_n_eff);
        if (n_entry.meta.tri_valid) begin
            n_entry.meta.tri_second = i_position;
            n_entry.meta.tri_third  = (i_position == r_n_eff) ? IDX_W'(1)
                                                              : i_position + IDX_W'(1);
        end
        // the closing vertex lands on a full turn, i.e. phase zero
        n_entry.rem = (w_k_minus1 == r_n_eff) ? '0 : w_k_minus1;
        n_entry.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_live <= 1'b0;
        end else begin
            r_entry_live <= n_entry.live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_comb begin
        div_bus[0] = r_entry;
        div_bus[0].live = r_entry_live;
    end

    // phase divider: one quotient bit per cell
    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
        efft_div_cell u_div_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_n     (r_n_eff),
            .i_item  (div_bus[gi]),
            .o_item  (div_bus[gi+1])
        );
    end

    // reduce the phase to the nearest axis and start the rotation
    always_comb begin
        w_biased = div_bus[DIV_STEPS].quo + EIGHTH_TURN;
        cordic_bus[0].live = div_bus[DIV_STEPS].live;
        cordic_bus[0].meta = div_bus[DIV_STEPS].meta;
        cordic_bus[0].quad = t_quad'(w_biased[PHASE_W-1:PHASE_W-2]);
        cordic_bus[0].x    = GAIN_Q30;
        cordic_bus[0].y    = '0;
        cordic_bus[0].z    = $signed(UNIT_W'({w_biased[PHASE_W-3:0],
                                              {(32-PHASE_W){1'b0}}})) - Q30_HALF;
    end

    // rotation chain
    for (genvar gc = 0; gc < CORDIC_STAGES; gc++) begin : g_cordic
        efft_cordic_cell #(
            .STAGE (gc)
        ) u_cordic_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (cordic_bus[gc]),
            .o_item  (cordic_bus[gc+1])
        );
    end

    // correction, scaling and output register
    efft_post u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (cordic_bus[CORDIC_STAGES]),
        .i_radius_x     (r_radius_x),
        .i_radius_y     (r_radius_y),
        .o_result_valid (o_result_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_tri_valid    (o_tri_valid),
        .o_tri_second   (o_tri_second),
        .o_tri_third    (o_tri_third),
        .o_index_error  (o_index_error)
    );

`ifndef SYNTHESIS
    // an out-of-range position never starts a triangle
    a_err_no_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_index_error && o_tri_valid))
        else $error("index error with a valid triangle");

    // an out-of-range position reports the center
    a_err_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_index_error) |-> (o_pos_x == '0 && o_pos_y == '0))
        else $error("index error with a nonzero vertex");

    // a triangle continues to the next vertex or closes to the first
    a_tri_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_tri_valid) |->
            (o_tri_second != '0) &&
            ((o_tri_third == o_tri_second + IDX_W'(1)) || (o_tri_third == IDX_W'(1))))
        else $error("fan triangle indices out of order");

    // saturation keeps both coordinates off the most negative code
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_pos_x != COORD_W'(-OUT_LIMIT - ROUND_W'(1))) &&
                           (o_pos_y != COORD_W'(-OUT_LIMIT - ROUND_W'(1))))
        else $error("vertex coordinate beyond saturation limit");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_ellipse_fan_tessellator.sv =====
// ----------------------------------------------------------------------------
// tb_ellipse_fan_tessellator: self-checking bench for the fan tessellator
// Positions go in through the start/busy command channel and each result is
// checked field by field against a fixed-point CORDIC vertex predictor. The
// radii and the segment count are rewritten over apb between phases with the
// pipeline empty. A short directed part covers the center, closing and
// out-of-range positions, the segment count clamps and the radius extremes.
// Random phases with varied command idling follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ellipse_fan_tessellator;

    timeunit 1ns;
    timeprecision 1ps;

    import efft_pkg::*;

    localparam int RESULT_LATENCY = 36;
    localparam int STALL_LIMIT    = 2000;
    localparam int PRINT_LIMIT    = 40;
    localparam int ROT_STAGES     = 16;
    localparam int SEG_MAX        = 4096;

    localparam longint UNIT_GAIN    = 64'sd652032874;
    localparam longint QUARTER_RAD  = 64'sd1686629713;
    localparam longint HALF_Q30     = 64'sd536870912;
    localparam longint COORD_LIMIT  = 64'sd65535;

    // arctangent of 2^-i in 2^-32 of a turn
    localparam longint ARCTAN_STEP [ROT_STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      tv;
        logic [IDX_W-1:0]          second;
        logic [IDX_W-1:0]          third;
        logic                      err;
    } t_fan_vertex;

    // dut signals
    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      psel       = 1'b0;
    logic                      penable    = 1'b0;
    logic                      pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr      = '0;
    logic [APB_DATA_W-1:0]     pwdata     = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      start      = 1'b0;
    logic                      busy;
    logic [IDX_W-1:0]          i_position = '0;
    logic                      o_result_valid;
    logic signed [COORD_W-1:0] o_pos_x;
    logic signed [COORD_W-1:0] o_pos_y;
    logic                      o_tri_valid;
    logic [IDX_W-1:0]          o_tri_second;
    logic [IDX_W-1:0]          o_tri_third;
    logic                      o_index_error;

    // register shadow
    logic [RAD_W-1:0] cfg_radius_x  = RADIUS_RESET;
    logic [RAD_W-1:0] cfg_radius_y  = RADIUS_RESET;
    logic [SEG_W-1:0] cfg_segments  = SEGMENT_RESET;

    logic [IDX_W-1:0] pending_positions [$];
    t_fan_vertex      expected_vertices [$];
    int               send_idle_pct  = 0;
    int               mismatch_count = 0;
    int               stall_cycles   = 0;

    ellipse_fan_tessellator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_position     (i_position),
        .o_result_valid (o_result_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_tri_valid    (o_tri_valid),
        .o_tri_second   (o_tri_second),
        .o_tri_third    (o_tri_third),
        .o_index_error  (o_index_error)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // effective segment count after the zero and maximum clamps
    function automatic int seg_limit(input logic [SEG_W-1:0] seg);
        int n;
        n = int'(seg);
        if (n == 0) n = 1;
        if (n > SEG_MAX) n = SEG_MAX;
        return n;
    endfunction

    // q2.30 cosine and sine of a 16-bit phase
    function automatic void rotate_unit(input logic [PHASE_W-1:0] phase,
                                        output longint cos_v, output longint sin_v);
        logic [31:0] biased;
        t_quad       quad;
        longint      x, y, z, dx, dy, zr, nx, ny;
        biased = {phase, 16'h0000} + 32'h2000_0000;
        quad   = t_quad'(biased[31:30]);
        z      = longint'(biased[29:0]) - HALF_Q30;
        x      = UNIT_GAIN;
        y      = 0;
        for (int i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
        end
        // first-order cleanup of the leftover angle
        zr = (z * QUARTER_RAD) >>> 30;
        nx = x - ((y * zr) >>> 30);
        ny = y + ((x * zr) >>> 30);
        case (quad)
            QUAD_EAST: begin
                cos_v = nx;
                sin_v = ny;
            end
            QUAD_NORTH: begin
                cos_v = -ny;
                sin_v = nx;
            end
            QUAD_WEST: begin
                cos_v = -nx;
                sin_v = -ny;
            end
            default: begin
                cos_v = ny;
                sin_v = -nx;
            end
        endcase
    endfunction

    // radius times unit component, rounded half up to q8.8 and saturated
    function automatic logic signed [COORD_W-1:0] scale_q88(input longint radius,
                                                            input longint unit_v);
        longint v;
        v = (radius * unit_v + HALF_Q30) >>> 30;
        if (v > COORD_LIMIT) v = COORD_LIMIT;
        if (v < -COORD_LIMIT) v = -COORD_LIMIT;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_fan_vertex predict_vertex(input logic [IDX_W-1:0] pos);
        t_fan_vertex      v;
        int               n, k;
        logic [PHASE_W-1:0] phase;
        longint           c, s;
        v = '0;
        n = seg_limit(cfg_segments);
        k = int'(pos);
        if (k > n + 1) begin
            v.err = 1'b1;
        end else if (k >= 1) begin
            phase = PHASE_W'((longint'(k - 1) * 65536) / n);
            rotate_unit(phase, c, s);
            v.x = scale_q88(longint'(cfg_radius_x), c);
            v.y = scale_q88(longint'(cfg_radius_y), s);
            if (k <= n) begin
                v.tv     = 1'b1;
                v.second = IDX_W'(k);
                v.third  = (k == n) ? IDX_W'(1) : IDX_W'(k + 1);
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                expected_vertices.insert(expected_vertices.size(),
                                         predict_vertex(i_position));
            if (!start || !busy) begin
                if (pending_positions.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    start      <= 1'b1;
                    i_position <= pending_positions.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_fan_vertex want;
        if (i_rst_n && o_result_valid) begin
            if (expected_vertices.size() == 0) begin
                report_mismatch("unexpected result", int'(o_pos_x), 0);
            end else begin
                want = expected_vertices.pop_front();
                if (o_pos_x !== want.x)
                    report_mismatch("pos_x", int'(o_pos_x), int'(want.x));
                if (o_pos_y !== want.y)
                    report_mismatch("pos_y", int'(o_pos_y), int'(want.y));
                if (o_tri_valid !== want.tv)
                    report_mismatch("tri_valid", int'(o_tri_valid), int'(want.tv));
                if (o_tri_second !== want.second)
                    report_mismatch("tri_second", int'(o_tri_second), int'(want.second));
                if (o_tri_third !== want.third)
                    report_mismatch("tri_third", int'(o_tri_third), int'(want.third));
                if (o_index_error !== want.err)
                    report_mismatch("index_error", int'(o_index_error), int'(want.err));
            end
        end
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ellipse_fan_tessellator test failed");
                $finish;
            end
        end
    end

    // apb write with setup and access phases, shadow updated at the write edge
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIUS_X:      cfg_radius_x = data[RAD_W-1:0];
            REG_RADIUS_Y:      cfg_radius_y = data[RAD_W-1:0];
            REG_SEGMENT_COUNT: cfg_segments = data[SEG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int rx, input int ry, input int seg);
        apb_write(REG_RADIUS_X, APB_DATA_W'(rx));
        apb_write(REG_RADIUS_Y, APB_DATA_W'(ry));
        apb_write(REG_SEGMENT_COUNT, APB_DATA_W'(seg));
    endtask

    // wait until every queued position has come back as a result
    task automatic drain();
        do @(negedge i_clk);
        while (pending_positions.size() != 0 || start || expected_vertices.size() != 0);
    endtask

    // append one position to the pending queue
    task automatic queue_position(input logic [IDX_W-1:0] pos);
        pending_positions.insert(pending_positions.size(), pos);
    endtask

    function automatic int random_radius();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2:       return 256;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_position(input int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)  return '0;
        if (r < 12) return IDX_W'(n + 1);
        if (r < 18) return IDX_W'(n);
        if (r < 24) return IDX_W'($urandom_range(n + 2, 8191));
        if (r < 28) return IDX_W'($urandom_range(0, 8191));
        return IDX_W'($urandom_range(1, n));
    endfunction

    // stimulus
    initial begin
        int dir_reset [$] = '{0, 1, 2, 9, 17, 25, 32, 33, 34, 8191, 4096};
        int dir_one   [$] = '{0, 1, 2, 3};
        int dir_two   [$] = '{1, 2, 3, 4};
        int dir_max   [$] = '{4096, 4097, 4098, 1, 2049};
        int idle_modes [3] = '{0, 59, 36};
        int seg;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: center, closing vertex, out of range
        send_idle_pct = 0;
        foreach (dir_reset[i]) queue_position(IDX_W'(dir_reset[i]));
        drain();

        // zero segments clamps to one, full radius saturates
        configure(65535, 65535, 0);
        send_idle_pct = 59;
        foreach (dir_one[i]) queue_position(IDX_W'(dir_one[i]));
        drain();

        // two segments: negative saturation on x, zero radius on y
        configure(65535, 0, 2);
        send_idle_pct = 36;
        foreach (dir_two[i]) queue_position(IDX_W'(dir_two[i]));
        drain();

        // segment count above the maximum clamps to it
        configure(0, 40000, 8191);
        send_idle_pct = 0;
        foreach (dir_max[i]) queue_position(IDX_W'(dir_max[i]));
        drain();

        // random phases
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 11))
                0:       seg = 0;
                1:       seg = 1;
                2:       seg = 2;
                3:       seg = 3;
                4:       seg = 4096;
                5:       seg = 4097;
                6:       seg = 8191;
                7:       seg = $urandom_range(4097, 8191);
                8, 9:    seg = $urandom_range(1, 64);
                default: seg = $urandom_range(1, 4096);
            endcase
            configure(random_radius(), random_radius(), seg);
            send_idle_pct = idle_modes[p % 3];
            repeat (135) queue_position(pick_position(seg_limit(cfg_segments)));
            drain();
        end

        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_vertices.size() == 0) begin
            $display("ellipse_fan_tessellator test passed");
        end else begin
            $display("ellipse_fan_tessellator test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
